// File: design/fbtg_pkg.sv
// ----------------------------------------------------------------------------
// fbtg_pkg
// Shared types and constants for the five-bit token gearbox.
// ----------------------------------------------------------------------------
package fbtg_pkg;

  // fixed field widths
  localparam int DATA_W     = 64;
  localparam int PAD_W      = 6;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int TOKEN_BITS = 5;

  // defaults
  localparam int MAX_UNIT_WIDTH_DEF = 64;
  localparam logic [CFG_W-1:0] UNIT_WIDTH_RESET = 7'd8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 1'b1;

  // direction codes
  localparam logic DIR_PACK   = 1'b0;
  localparam logic DIR_UNPACK = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;  // output register free this cycle
    logic step_last;  // current step consumes the rest of the item
    logic step_emit;  // current step completes a unit or token
    logic last;       // item in progress closes the stream
  } status_t;

endpackage

// File: design/fbtg_if.sv
// ----------------------------------------------------------------------------
// fbtg_in_if / fbtg_out_if
// Valid/ready stream channels for gearbox input items and result items.
// ----------------------------------------------------------------------------
interface fbtg_in_if;
  logic                        valid;
  logic                        ready;
  logic [fbtg_pkg::DATA_W-1:0] data_in;
  logic                        stream_end;

  modport source (output valid, output data_in, output stream_end, input ready);
  modport sink   (input valid, input data_in, input stream_end, output ready);
endinterface

interface fbtg_out_if;
  logic                        valid;
  logic                        ready;
  logic [fbtg_pkg::DATA_W-1:0] data_out;
  logic [fbtg_pkg::PAD_W-1:0]  pad_bits;
  logic                        run_end;
  logic                        stream_done;

  modport source (output valid, output data_out, output pad_bits, output run_end,
                  output stream_done, input ready);
  modport sink   (input valid, input data_out, input pad_bits, input run_end,
                  input stream_done, output ready);
endinterface

// File: design/five_bit_token_gearbox_core.sv
// ----------------------------------------------------------------------------
// five_bit_token_gearbox_core
// Gearbox between 5-bit tokens and N-bit units, MSB first, with flush.
// ----------------------------------------------------------------------------
// Items are handled one at a time. An accepted item is loaded, then stepped
// through chunk by chunk: a chunk is as many of the item's bits as fill the
// current unit or token, so the chunk count is the number of results the item
// completes, plus one if bits are left over. A stream end with bits left adds
// a flush step. The chunk step is a variable shift into the residual store;
// output stalls hold the step and the flush until the result register is
// free. Input ready is high only between items. Writing a configuration
// register clears the residual store.
module five_bit_token_gearbox_core #(
  parameter int MAX_UNIT_WIDTH = fbtg_pkg::MAX_UNIT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fbtg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fbtg_pkg::CFG_W-1:0]     cfg_wdata_i,
  fbtg_in_if.sink                        in_i,
  fbtg_out_if.source                     out_o
);

  fbtg_pkg::cmd_t    cmd;
  fbtg_pkg::status_t status;

  // sequencer
  fbtg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // bit datapath
  fbtg_datapath #(
    .MAX_UNIT_WIDTH (MAX_UNIT_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .data_in_i     (in_i.data_in),
    .stream_end_i  (in_i.stream_end),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .data_out_o    (out_o.data_out),
    .pad_bits_o    (out_o.pad_bits),
    .run_end_o     (out_o.run_end),
    .stream_done_o (out_o.stream_done)
  );

endmodule

// File: design/fbtg_ctrl.sv
// ----------------------------------------------------------------------------
// fbtg_ctrl
// Sequencer: loads an item, steps chunks through the datapath, then flushes leftover bits at stream end.
// ----------------------------------------------------------------------------
module fbtg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fbtg_pkg::status_t status_i,
  output fbtg_pkg::cmd_t    cmd_o
);

  fbtg_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbtg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fbtg_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = fbtg_pkg::ST_RUN;
      end
      fbtg_pkg::ST_RUN: begin
        if (status_i.slot_free && status_i.step_last) begin
          // leftover bits at stream end need one more result
          if (!status_i.step_emit && status_i.last) state_d = fbtg_pkg::ST_FLUSH;
          else state_d = fbtg_pkg::ST_IDLE;
        end
      end
      fbtg_pkg::ST_FLUSH: begin
        if (status_i.slot_free) state_d = fbtg_pkg::ST_IDLE;
      end
      default: state_d = fbtg_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      fbtg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      fbtg_pkg::ST_RUN:   cmd_o.step  = status_i.slot_free;
      fbtg_pkg::ST_FLUSH: cmd_o.flush = status_i.slot_free;
      default: ;
    endcase
  end

endmodule

// File: design/fbtg_datapath.sv
// ----------------------------------------------------------------------------
// fbtg_datapath
// Config registers, input bit buffer, residual store and output register.
// ----------------------------------------------------------------------------
module fbtg_datapath #(
  parameter int MAX_UNIT_WIDTH = fbtg_pkg::MAX_UNIT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fbtg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fbtg_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [fbtg_pkg::DATA_W-1:0]    data_in_i,
  input  logic                           stream_end_i,
  input  fbtg_pkg::cmd_t                 cmd_i,
  output fbtg_pkg::status_t              status_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [fbtg_pkg::DATA_W-1:0]    data_out_o,
  output logic [fbtg_pkg::PAD_W-1:0]     pad_bits_o,
  output logic                           run_end_o,
  output logic                           stream_done_o
);

  localparam int W  = MAX_UNIT_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [fbtg_pkg::CFG_W-1:0] unit_width_q;
  logic                       direction_q;
  logic [W-1:0]               inbuf_q;   // pending input bits, MSB aligned
  logic [CW-1:0]              rem_q;
  logic [W-1:0]               res_q;     // residual bits, right aligned
  logic [CW-1:0]              cnt_q;
  logic                       last_q;
  logic                       out_valid_q;
  logic [fbtg_pkg::DATA_W-1:0] out_data_q;
  logic [fbtg_pkg::PAD_W-1:0]  out_pad_q;
  logic                        out_run_end_q;
  logic                        out_done_q;

  logic [CW-1:0] n_w, target_w, space_w, take_w, cnt_next_w, rem_next_w;
  logic [W-1:0]  chunk_w, res_next_w, flush_data_w;
  logic          emit_w, step_last_w, slot_free_w, run_end_w;

  // effective unit width, clamped to 1..W
  always_comb begin
    if (unit_width_q == '0) n_w = CW'(1);
    else if (int'(unit_width_q) > W) n_w = CW'(W);
    else n_w = unit_width_q[CW-1:0];
  end

  // one chunk step: take as many bits as fit into the current target
  assign target_w     = (direction_q == fbtg_pkg::DIR_UNPACK) ? CW'(fbtg_pkg::TOKEN_BITS) : n_w;
  assign space_w      = target_w - cnt_q;
  assign take_w       = (rem_q < space_w) ? rem_q : space_w;
  assign chunk_w      = inbuf_q >> (CW'(W) - take_w);
  assign res_next_w   = (res_q << take_w) | chunk_w;
  assign cnt_next_w   = cnt_q + take_w;
  assign rem_next_w   = rem_q - take_w;
  assign emit_w       = (cnt_next_w == target_w);
  assign step_last_w  = (rem_q <= space_w);
  assign flush_data_w = res_q << space_w;
  assign slot_free_w  = !out_valid_q || out_ready_i;

  // last result of the item: nothing more completes and no flush follows
  assign run_end_w    = step_last_w || (!last_q && (rem_next_w < target_w));

  assign status_o.slot_free = slot_free_w;
  assign status_o.step_last = step_last_w;
  assign status_o.step_emit = emit_w;
  assign status_o.last      = last_q;

  // config registers and residual store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_width_q <= fbtg_pkg::UNIT_WIDTH_RESET;
      direction_q  <= fbtg_pkg::DIR_PACK;
      res_q        <= '0;
      cnt_q        <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fbtg_pkg::CFG_UNIT_WIDTH) unit_width_q <= cfg_wdata_i;
      else direction_q <= cfg_wdata_i[0];
      res_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.flush || (cmd_i.step && emit_w)) begin
      res_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      res_q <= res_next_w;
      cnt_q <= cnt_next_w;
    end
  end

  // input bit buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (cmd_i.load) begin
      if (direction_q == fbtg_pkg::DIR_UNPACK) begin
        rem_q <= n_w;
      end else begin
        rem_q <= CW'(fbtg_pkg::TOKEN_BITS);
      end
    end else if (cmd_i.step) begin
      rem_q <= rem_next_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      last_q <= stream_end_i;
      if (direction_q == fbtg_pkg::DIR_UNPACK) begin
        inbuf_q <= data_in_i[W-1:0] << (CW'(W) - n_w);
      end else begin
        inbuf_q <= {data_in_i[fbtg_pkg::TOKEN_BITS-1:0], {(W-fbtg_pkg::TOKEN_BITS){1'b0}}};
      end
    end else if (cmd_i.step) begin
      inbuf_q <= inbuf_q << take_w;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.flush || (cmd_i.step && emit_w)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.flush) begin
      out_data_q    <= fbtg_pkg::DATA_W'(flush_data_w);
      out_pad_q     <= fbtg_pkg::PAD_W'(space_w);
      out_run_end_q <= 1'b1;
      out_done_q    <= 1'b1;
    end else if (cmd_i.step && emit_w) begin
      out_data_q    <= fbtg_pkg::DATA_W'(res_next_w);
      out_pad_q     <= '0;
      out_run_end_q <= run_end_w;
      out_done_q    <= step_last_w && last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_out_o    = out_data_q;
  assign pad_bits_o    = out_pad_q;
  assign run_end_o     = out_run_end_q;
  assign stream_done_o = out_done_q;

  // residual never reaches its target between steps
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q < target_w)
    else $error("residual count reached target");

  // a flush only happens with bits pending
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.flush |-> cnt_q != '0)
    else $error("flush with empty residual");

  // padding only on the closing result of a stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_pad_q != '0) |-> (out_done_q && out_run_end_q))
    else $error("padded result not marked as stream end");

  // no result is written over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step || cmd_i.flush) |-> slot_free_w)
    else $error("output register overwritten");

endmodule

// File: verif/five_bit_token_gearbox_core_tb.sv
// ----------------------------------------------------------------------------
// five_bit_token_gearbox_core_tb
// Self-checking testbench for the five-bit token gearbox core.
// ----------------------------------------------------------------------------
// Drives 5-bit tokens or N-bit units into the input channel and predicts every
// unit, token and flush result from a bit-serial model of the residual store.
// Directed tests cover the width extremes, exact fits with no flush, maximum
// padding and discard on reconfiguration. Random streams then run under four
// idling phases. Every transfer on the output channel is checked in order.
// ----------------------------------------------------------------------------
module five_bit_token_gearbox_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W            = fbtg_pkg::DATA_W;
  localparam int PAD_W             = fbtg_pkg::PAD_W;
  localparam int CFG_W             = fbtg_pkg::CFG_W;
  localparam int CFG_IDX_W         = fbtg_pkg::CFG_IDX_W;
  localparam int MAX_UNIT_W        = fbtg_pkg::MAX_UNIT_WIDTH_DEF;
  localparam int CLK_HALF          = 6;
  localparam int RESET_CYCLES      = 6;
  localparam int DRAIN_CYCLES      = 24;
  localparam int CYCLE_LIMIT       = 250000;
  localparam int ITEMS_PER_SETTING = 16;
  localparam int MAX_REPORTS       = 10;

  // one expected transfer on the output channel
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [PAD_W-1:0]  pad;
    logic              run_end;
    logic              stream_done;
  } gear_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  fbtg_in_if  in_ch ();
  fbtg_out_if out_ch ();

  five_bit_token_gearbox_core #(
    .MAX_UNIT_WIDTH(MAX_UNIT_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // predictor state: configuration and residual bit store
  logic [CFG_W-1:0]  cfg_unit_w;
  logic              cfg_dir;
  logic [DATA_W-1:0] resid_bits;
  int                resid_cnt;

  gear_result_t pending_outputs[$];

  int send_idle_pct;
  int stall_pct;
  int items_sent;
  int results_seen;
  int cfg_writes;
  int mismatches;
  int cycle_count;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_outputs.size());
    $display("[five_bit_token_gearbox_core] ERROR");
    $finish;
  end

  // receiver: random backpressure per current phase
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // shift one item through the model, queue the results it completes
  function automatic void shift_through_gearbox(input logic [DATA_W-1:0] din,
                                                input logic last);
    int           n;
    int           in_w;
    int           target;
    int           pad;
    gear_result_t res;
    logic         have_res;
    n = (cfg_unit_w == 0) ? 1 : ((cfg_unit_w > MAX_UNIT_W) ? MAX_UNIT_W : int'(cfg_unit_w));
    if (cfg_dir == fbtg_pkg::DIR_PACK) begin
      in_w   = fbtg_pkg::TOKEN_BITS;
      target = n;
    end else begin
      in_w   = n;
      target = fbtg_pkg::TOKEN_BITS;
    end
    have_res = 1'b0;
    res      = '0;
    for (int i = in_w; i > 0; i--) begin
      resid_bits = {resid_bits[DATA_W-2:0], din[i-1]};
      resid_cnt++;
      if (resid_cnt >= target) begin
        if (have_res) pending_outputs.push_back(res);
        res       = '0;
        res.data  = resid_bits;
        have_res  = 1'b1;
        resid_bits = '0;
        resid_cnt  = 0;
      end
    end
    // flush: left-align the leftover bits, zero pad below
    if (last && resid_cnt > 0) begin
      if (have_res) pending_outputs.push_back(res);
      pad        = target - resid_cnt;
      res        = '0;
      res.data   = resid_bits << pad;
      res.pad    = PAD_W'(pad);
      have_res   = 1'b1;
      resid_bits = '0;
      resid_cnt  = 0;
    end
    if (have_res) begin
      res.run_end     = 1'b1;
      res.stream_done = last;
      pending_outputs.push_back(res);
    end
  endfunction

  // output checker
  always @(posedge clk_i) begin
    gear_result_t exp_res;
    gear_result_t got_res;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      got_res.data        = out_ch.data_out;
      got_res.pad         = out_ch.pad_bits;
      got_res.run_end     = out_ch.run_end;
      got_res.stream_done = out_ch.stream_done;
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected transfer at cycle %0d: data=%h pad=%0d run_end=%b done=%b",
                   cycle_count, got_res.data, got_res.pad, got_res.run_end,
                   got_res.stream_done);
      end else begin
        exp_res = pending_outputs.pop_front();
        if (got_res.data !== exp_res.data || got_res.pad !== exp_res.pad ||
            got_res.run_end !== exp_res.run_end ||
            got_res.stream_done !== exp_res.stream_done) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d", cycle_count);
            $display("  expected data=%h pad=%0d run_end=%b done=%b", exp_res.data,
                     exp_res.pad, exp_res.run_end, exp_res.stream_done);
            $display("  actual   data=%h pad=%0d run_end=%b done=%b", got_res.data,
                     got_res.pad, got_res.run_end, got_res.stream_done);
          end
        end
      end
    end
  end

  // one input transfer, with an optional idle gap ahead of it
  task automatic send_item(input logic [DATA_W-1:0] din, input logic last);
    @(negedge clk_i);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_ch.valid      = 1'b1;
    in_ch.data_in    = din;
    in_ch.stream_end = last;
    do @(posedge clk_i); while (!in_ch.ready);
    shift_through_gearbox(din, last);
    items_sent++;
  endtask

  // drop valid, let every result arrive, then let the core settle
  task automatic wait_for_drain();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
    wait_for_drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == fbtg_pkg::CFG_UNIT_WIDTH) cfg_unit_w = value;
    else                                 cfg_dir    = value[0];
    resid_bits = '0;
    resid_cnt  = 0;
    cfg_writes++;
  endtask

  // token value in the low bits, random junk above
  function automatic logic [DATA_W-1:0] token_item(input logic [4:0] tok);
    return {$urandom, $urandom} & ~64'h1F | DATA_W'(tok);
  endfunction

  // reset settings: pack into 8-bit units, ignored upper bits, flush of 7 bits
  task automatic test_default_pack();
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_item(64'hFFFF_FFFF_FFFF_FFE0, 1'b0);
    send_item(token_item(5'h15), 1'b1);
  endtask

  // width 0 acts as 1 with no flush; width 64 with the largest pad
  task automatic test_pack_width_extremes();
    write_register(fbtg_pkg::CFG_UNIT_WIDTH, 7'd0);
    send_item(token_item(5'h1B), 1'b1);
    write_register(fbtg_pkg::CFG_UNIT_WIDTH, 7'd64);
    for (int i = 0; i < 13; i++)
      send_item(token_item((i % 2) ? 5'h00 : 5'h1F), i == 12);
  endtask

  // unpack at 64, above range, 1 bit and an exact 5-bit fit
  task automatic test_unpack_widths();
    write_register(fbtg_pkg::CFG_DIRECTION, CFG_W'(fbtg_pkg::DIR_UNPACK));
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    write_register(fbtg_pkg::CFG_UNIT_WIDTH, 7'd127);
    send_item({$urandom, $urandom}, 1'b1);
    write_register(fbtg_pkg::CFG_UNIT_WIDTH, 7'd1);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    write_register(fbtg_pkg::CFG_UNIT_WIDTH, 7'd5);
    send_item(64'hFFFF_FFFF_FFFF_FFEA, 1'b1);
  endtask

  // a register write in mid-stream throws the pending bits away
  task automatic test_reconfig_discard();
    write_register(fbtg_pkg::CFG_UNIT_WIDTH, 7'd7);
    send_item(64'h0000_0000_0000_007F, 1'b0);
    write_register(fbtg_pkg::CFG_UNIT_WIDTH, 7'd7);
    send_item(64'h0000_0000_0000_0055, 1'b1);
  endtask

  // random streams under each idling phase, two settings per phase
  task automatic test_random_traffic();
    int               sent;
    int               len;
    logic [CFG_W-1:0] w;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 55; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 55; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      for (int setting = 0; setting < 2; setting++) begin
        case ($urandom_range(0, 5))
          0:       w = 7'd0;
          1:       w = 7'd1;
          2:       w = 7'd64;
          3:       w = CFG_W'($urandom_range(65, 127));
          default: w = CFG_W'($urandom_range(2, 63));
        endcase
        write_register(fbtg_pkg::CFG_UNIT_WIDTH, w);
        write_register(fbtg_pkg::CFG_DIRECTION,
                       ($urandom_range(1) == 0) ? CFG_W'(fbtg_pkg::DIR_PACK)
                                                : CFG_W'(fbtg_pkg::DIR_UNPACK));
        // the last stream may be cut short and discarded by the next write
        sent = 0;
        while (sent < ITEMS_PER_SETTING) begin
          len = $urandom_range(1, 14);
          for (int j = 0; j < len && sent < ITEMS_PER_SETTING; j++) begin
            send_item({$urandom, $urandom}, j == len - 1);
            sent++;
          end
        end
      end
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // main sequence
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = fbtg_pkg::CFG_UNIT_WIDTH;
    cfg_wdata_i      = '0;
    in_ch.valid      = 1'b0;
    in_ch.data_in    = '0;
    in_ch.stream_end = 1'b0;
    cfg_unit_w       = fbtg_pkg::UNIT_WIDTH_RESET;
    cfg_dir          = fbtg_pkg::DIR_PACK;
    resid_bits       = '0;
    resid_cnt        = 0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    items_sent       = 0;
    results_seen     = 0;
    cfg_writes       = 0;
    mismatches       = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_pack();
    test_pack_width_extremes();
    test_unpack_widths();
    test_reconfig_discard();
    test_random_traffic();
    wait_for_drain();

    $display("sent %0d items in pack and unpack modes, checked %0d results, %0d mismatches",
             items_sent, results_seen, mismatches);
    $display("%0d register writes, widths from 0 to 127, four idling phases", cfg_writes);
    if (mismatches == 0) begin
      $display("[five_bit_token_gearbox_core] OK");
    end else begin
      $display("[five_bit_token_gearbox_core] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
design/fbtg_pkg.sv
design/fbtg_if.sv
design/fbtg_ctrl.sv
design/fbtg_datapath.sv
design/five_bit_token_gearbox_core.sv
verif/five_bit_token_gearbox_core_tb.sv
